// File: rtl/core/q248_pkg.sv
// Shared constants for the Q24.8 fixed-point arithmetic unit.
`default_nettype none
package q248_pkg;
	localparam int WORD_W        = 32;
	localparam int DEF_FRAC_BITS = 8;

	localparam logic [3:0] OP_ADD      = 4'd0;
	localparam logic [3:0] OP_SUB      = 4'd1;
	localparam logic [3:0] OP_MUL      = 4'd2;
	localparam logic [3:0] OP_DIV      = 4'd3;
	localparam logic [3:0] OP_MIN      = 4'd4;
	localparam logic [3:0] OP_MAX      = 4'd5;
	localparam logic [3:0] OP_INC      = 4'd6;
	localparam logic [3:0] OP_DEC      = 4'd7;
	localparam logic [3:0] OP_FROM_INT = 4'd8;
	localparam logic [3:0] OP_FROM_FLT = 4'd9;
	localparam logic [3:0] OP_TO_INT   = 4'd10;
	localparam logic [3:0] OP_TO_FLT   = 4'd11;

	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_DIV0  = 2'd1;
	localparam logic [1:0] ERR_FLOAT = 2'd2;
endpackage
`default_nettype wire

// File: rtl/core/q248_div_cell.sv
// One restoring-division cell: produces one quotient bit per beat.
`default_nettype none
module q248_div_cell #(
	parameter int DVD_W = 40
) (
	input  wire logic                         clk,
	input  wire logic [q248_pkg::WORD_W-1:0]  prev_rem,
	input  wire logic [DVD_W-1:0]             prev_dvd,
	input  wire logic [q248_pkg::WORD_W-1:0]  prev_dsr,
	input  wire logic [q248_pkg::WORD_W-1:0]  prev_quo,
	output logic      [q248_pkg::WORD_W-1:0]  rem_q,
	output logic      [DVD_W-1:0]             dvd_q,
	output logic      [q248_pkg::WORD_W-1:0]  dsr_q,
	output logic      [q248_pkg::WORD_W-1:0]  quo_q
);
	localparam int W = q248_pkg::WORD_W;

	logic [W:0] trial;
	logic [W:0] diff;
	logic       take;

	// Bring down the next dividend bit and try to subtract the divisor.
	assign trial = {prev_rem, prev_dvd[DVD_W-1]};
	assign diff  = trial - {1'b0, prev_dsr};
	assign take  = trial >= {1'b0, prev_dsr};

	always_ff @(posedge clk) begin
		rem_q <= take ? diff[W-1:0] : trial[W-1:0];
		dvd_q <= {prev_dvd[DVD_W-2:0], 1'b0};
		dsr_q <= prev_dsr;
		quo_q <= {prev_quo[W-2:0], take};
	end
endmodule
`default_nettype wire

// File: rtl/core/fixed_point_q24_8_alu.sv
// Top level of the pipelined signed fixed-point arithmetic unit.
//
//  channel  | handshake           | payload
//  ---------+---------------------+----------------------------------------------
//  command  | start, busy         | opcode, operand_a, operand_b
//  result   | done (one cycle)    | result_value, a_less, a_equal, a_greater,
//           |                     | error_code
//
// A command beat is taken at every clock edge where start is high; busy is
// always low, so one beat enters per cycle. Every beat yields one result,
// in order of entry. The divider is a row of 32 + FRAC_BITS cells, each
// producing one quotient bit per cycle; all other operations finish in
// two stages and ride a matching delay line. Reset clears only the valid
// bits of the pipeline. The receiver cannot stall, so nothing ever backs up.
`default_nettype none
module fixed_point_q24_8_alu #(
	parameter int FRAC_BITS = q248_pkg::DEF_FRAC_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic        [3:0]                  opcode,
	input  wire logic signed [q248_pkg::WORD_W-1:0] operand_a,
	input  wire logic signed [q248_pkg::WORD_W-1:0] operand_b,
	output logic                                    done,
	output logic signed      [q248_pkg::WORD_W-1:0] result_value,
	output logic                                    a_less,
	output logic                                    a_equal,
	output logic                                    a_greater,
	output logic             [1:0]                  error_code
);
	localparam int W   = q248_pkg::WORD_W;
	localparam int NQ  = W + FRAC_BITS;  // quotient bits, one cell each
	localparam int LAT = NQ + 2;

	typedef struct packed {
		logic          is_div;
		logic          dz;
		logic          neg;
		logic [W-1:0]  res;
		logic [1:0]    err;
		logic          lt;
		logic          eq;
		logic          gt;
	} side_t;

	// Float bit pattern to fixed: bit 32 flags an error, bits 31:0 hold the value.
	function automatic logic [W:0] flt_to_fix(logic [W-1:0] f);
		logic        neg;
		logic [7:0]  e;
		logic [23:0] m;
		logic [63:0] mag;
		logic [W-1:0] sat;
		int          sh;
		int          r;
		neg = f[31];
		e   = f[30:23];
		m   = {(e != 8'd0), f[22:0]};
		sat = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		sh  = (e == 8'd0) ? (FRAC_BITS - 149) : (int'(e) - 150 + FRAC_BITS);
		mag = '0;
		r   = -sh;
		if (e == 8'hFF) begin
			flt_to_fix = (f[22:0] != 23'd0) ? {1'b1, 32'd0} : {1'b1, sat};
		end else if (m == 24'd0) begin
			flt_to_fix = '0;
		end else if (sh > 39) begin
			flt_to_fix = {1'b1, sat};
		end else begin
			if (sh >= 0) begin
				mag = {40'd0, m} << sh[5:0];
			end else if (r <= 25) begin
				mag = {40'd0, (m >> r[4:0])} +
					(({40'd0, m} >> (r[4:0] - 5'd1)) & 64'd1);
			end
			if (!neg && mag > 64'h7FFF_FFFF) begin
				flt_to_fix = {1'b1, 32'h7FFF_FFFF};
			end else if (neg && mag > 64'h8000_0000) begin
				flt_to_fix = {1'b1, 32'h8000_0000};
			end else begin
				flt_to_fix = {1'b0, (neg ? (32'd0 - mag[W-1:0]) : mag[W-1:0])};
			end
		end
	endfunction

	// Fixed value magnitude with its leading-one position to IEEE single.
	function automatic logic [W-1:0] fix_to_flt(logic sign, logic [W-1:0] mag,
			logic [4:0] p);
		logic [24:0] q;
		logic [W-1:0] rem;
		logic [W-1:0] half;
		logic [5:0]  pp;
		logic [3:0]  sh;
		logic [7:0]  biased;
		q    = '0;
		pp   = {1'b0, p};
		sh   = '0;
		rem  = '0;
		half = '0;
		if (p <= 5'd23) begin
			q = 25'(mag << (5'd23 - p));
		end else begin
			sh   = 4'(p - 5'd23);
			rem  = mag & ((32'd1 << sh) - 32'd1);
			half = 32'd1 << (sh - 4'd1);
			q    = 25'(mag >> sh);
			if (rem > half || (rem == half && q[0])) begin
				q = q + 25'd1;
			end
			if (q[24]) begin
				q  = q >> 1;
				pp = pp + 6'd1;
			end
		end
		biased = 8'(int'(pp) + 127 - FRAC_BITS);
		fix_to_flt = (mag == '0) ? '0 : {sign, biased, q[22:0]};
	endfunction

	// Stage 1: operands, the product and the divider operands.
	logic                accept;
	logic                valid_s1;
	logic [3:0]          op_s1;
	logic signed [W-1:0] a_s1;
	logic signed [W-1:0] b_s1;
	logic signed [63:0]  prod_s1;
	logic [W-1:0]        mag_s1;
	logic [4:0]          p_s1;
	logic [NQ-1:0]       dvd_s1;
	logic [W-1:0]        dsr_s1;
	logic [W-1:0]        mag_a;
	logic [4:0]          p_a;

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign mag_a  = operand_a[W-1] ? (32'd0 - operand_a) : operand_a;

	always_comb begin
		p_a = '0;
		for (int i = 0; i < W; i++) begin
			if (mag_a[i]) begin
				p_a = 5'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= opcode;
		a_s1    <= operand_a;
		b_s1    <= operand_b;
		prod_s1 <= operand_a * operand_b;
		mag_s1  <= mag_a;
		p_s1    <= p_a;
		dvd_s1  <= {mag_a, {FRAC_BITS{1'b0}}};
		dsr_s1  <= operand_b[W-1] ? (32'd0 - operand_b) : operand_b;
	end

	// Stage 2: every operation other than division settles here.
	side_t      side_d;
	logic [W:0] f2x;

	assign f2x = flt_to_fix(a_s1);

	always_comb begin
		side_d        = '0;
		side_d.is_div = (op_s1 == q248_pkg::OP_DIV);
		side_d.dz     = (b_s1 == '0);
		side_d.neg    = a_s1[W-1] ^ b_s1[W-1];
		side_d.lt     = a_s1 < b_s1;
		side_d.eq     = a_s1 == b_s1;
		side_d.gt     = a_s1 > b_s1;
		side_d.err    = q248_pkg::ERR_NONE;
		unique case (op_s1)
			q248_pkg::OP_ADD:      side_d.res = a_s1 + b_s1;
			q248_pkg::OP_SUB:      side_d.res = a_s1 - b_s1;
			q248_pkg::OP_MUL:      side_d.res = prod_s1[FRAC_BITS +: W];
			q248_pkg::OP_MIN:      side_d.res = (a_s1 < b_s1) ? a_s1 : b_s1;
			q248_pkg::OP_MAX:      side_d.res = (a_s1 > b_s1) ? a_s1 : b_s1;
			q248_pkg::OP_INC:      side_d.res = a_s1 + 32'sd1;
			q248_pkg::OP_DEC:      side_d.res = a_s1 - 32'sd1;
			q248_pkg::OP_FROM_INT: side_d.res = a_s1 << FRAC_BITS;
			q248_pkg::OP_TO_INT:   side_d.res = a_s1 >>> FRAC_BITS;
			q248_pkg::OP_TO_FLT:   side_d.res = fix_to_flt(a_s1[W-1], mag_s1, p_s1);
			q248_pkg::OP_FROM_FLT: begin
				side_d.res = f2x[W-1:0];
				side_d.err = f2x[W] ? q248_pkg::ERR_FLOAT : q248_pkg::ERR_NONE;
			end
			default:               side_d.res = '0;
		endcase
	end

	// Delay line that keeps the fast results in step with the divider.
	side_t         side_pipe [0:NQ-1];
	logic [NQ-1:0] vpipe_q;

	always_ff @(posedge clk) begin
		side_pipe[0] <= side_d;
		for (int k = 1; k < NQ; k++) begin
			side_pipe[k] <= side_pipe[k-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vpipe_q <= '0;
		end else begin
			vpipe_q <= {vpipe_q[NQ-2:0], valid_s1};
		end
	end

	// The divider row: each cell brings down one dividend bit.
	logic [W-1:0]  rem_c [0:NQ];
	logic [NQ-1:0] dvd_c [0:NQ];
	logic [W-1:0]  dsr_c [0:NQ];
	logic [W-1:0]  quo_c [0:NQ];

	assign rem_c[0] = '0;
	assign dvd_c[0] = dvd_s1;
	assign dsr_c[0] = dsr_s1;
	assign quo_c[0] = '0;

	for (genvar k = 0; k < NQ; k++) begin : g_cell
		q248_div_cell #(
			.DVD_W(NQ)
		) u_cell (
			.clk      (clk),
			.prev_rem (rem_c[k]),
			.prev_dvd (dvd_c[k]),
			.prev_dsr (dsr_c[k]),
			.prev_quo (quo_c[k]),
			.rem_q    (rem_c[k+1]),
			.dvd_q    (dvd_c[k+1]),
			.dsr_q    (dsr_c[k+1]),
			.quo_q    (quo_c[k+1])
		);
	end

	// Output stage: pick the quotient for divisions, with sign and zero guard.
	side_t        side_o;
	logic [W-1:0] quo_o;

	assign side_o = side_pipe[NQ-1];
	assign quo_o  = quo_c[NQ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vpipe_q[NQ-1];
		end
	end

	always_ff @(posedge clk) begin
		a_less    <= side_o.lt;
		a_equal   <= side_o.eq;
		a_greater <= side_o.gt;
		if (side_o.is_div) begin
			result_value <= side_o.dz ? '0 : (side_o.neg ? (32'd0 - quo_o) : quo_o);
			error_code   <= side_o.dz ? q248_pkg::ERR_DIV0 : q248_pkg::ERR_NONE;
		end else begin
			result_value <= side_o.res;
			error_code   <= side_o.err;
		end
	end

	// Every accepted beat comes out after the fixed pipeline latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("result strobe missing after pipeline latency");

	// Exactly one comparison flag holds on every result.
	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot({a_less, a_equal, a_greater}))
		else $error("comparison flags not one-hot");

	// A divide-by-zero result is always zero.
	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error_code == q248_pkg::ERR_DIV0) |-> (result_value == '0))
		else $error("divide by zero gave nonzero result");

	// The error code never takes the unused value.
	a_err_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (error_code != 2'd3))
		else $error("error code out of range");
endmodule
`default_nettype wire

// File: dv/fixed_point_q24_8_alu_tb.sv
// Self-checking testbench for the Q24.8 fixed-point arithmetic unit.
module fixed_point_q24_8_alu_tb;
	localparam int FB         = q248_pkg::DEF_FRAC_BITS;
	localparam int LATENCY    = 34 + FB;
	localparam int N_RANDOM   = 1000;
	localparam int WDOG_LIMIT = 4 * LATENCY + 200;

	// One operation result as the block reports it.
	typedef struct packed {
		logic [31:0] value;
		logic        lt;
		logic        eq;
		logic        gt;
		logic [1:0]  err;
	} alu_result_t;

	// A directed row: the command, and an optional hand-typed answer.
	typedef struct {
		logic [3:0]  op;
		logic [31:0] a;
		logic [31:0] b;
		bit          typed;
		alu_result_t res;
	} alu_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [3:0]  opcode;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	logic        done;
	logic [31:0] result_value;
	logic        a_less;
	logic        a_equal;
	logic        a_greater;
	logic [1:0]  error_code;

	alu_result_t pending_results[$];
	int          error_count;
	int          idle_cycles;

	fixed_point_q24_8_alu #(.FRAC_BITS(FB)) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.opcode       (opcode),
		.operand_a    (operand_a),
		.operand_b    (operand_b),
		.done         (done),
		.result_value (result_value),
		.a_less       (a_less),
		.a_equal      (a_equal),
		.a_greater    (a_greater),
		.error_code   (error_code)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Converts an IEEE single bit pattern to a raw fixed value, rounding half
	// away from zero and saturating out-of-range inputs.
	function automatic logic [31:0] float_to_raw(input logic [31:0] f, output logic [1:0] err);
		logic        neg;
		int          e;
		int          s;
		int          r;
		logic [63:0] m;
		logic [63:0] mag;
		neg = f[31];
		e   = f[30:23];
		m   = {41'd0, f[22:0]};
		err = q248_pkg::ERR_NONE;
		if (e == 255) begin
			err = q248_pkg::ERR_FLOAT;
			if (m != 0)
				return 32'd0;
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end
		if (e == 0) begin
			s = -149 + FB;
		end else begin
			m[23] = 1'b1;
			s = e - 150 + FB;
		end
		if (m == 0)
			return 32'd0;
		if (s >= 0) begin
			if (s > 39) begin
				err = q248_pkg::ERR_FLOAT;
				return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
			end
			mag = m << s;
		end else begin
			r = -s;
			if (r > 25)
				mag = 64'd0;
			else
				mag = (m >> r) + ((m >> (r - 1)) & 64'd1);
		end
		if (!neg && mag > 64'h7FFF_FFFF) begin
			err = q248_pkg::ERR_FLOAT;
			return 32'h7FFF_FFFF;
		end
		if (neg && mag > 64'h8000_0000) begin
			err = q248_pkg::ERR_FLOAT;
			return 32'h8000_0000;
		end
		return neg ? 32'(-mag) : mag[31:0];
	endfunction

	// Converts a raw fixed value to an IEEE single with round to nearest even.
	function automatic logic [31:0] raw_to_float(input logic signed [31:0] a);
		logic [63:0] mag;
		logic [63:0] q;
		logic [63:0] rem;
		logic [63:0] half;
		int          p;
		int          sh;
		mag = (a < 0) ? 64'(-64'(a)) : 64'(a);
		if (mag == 0)
			return 32'd0;
		p = 0;
		while ((mag >> (p + 1)) != 0)
			p++;
		if (p <= 23) begin
			q = mag << (23 - p);
		end else begin
			sh   = p - 23;
			rem  = mag & ((64'd1 << sh) - 64'd1);
			half = 64'd1 << (sh - 1);
			q    = mag >> sh;
			if (rem > half || (rem == half && q[0]))
				q++;
			if (q >> 24) begin
				q = q >> 1;
				p++;
			end
		end
		return {a < 0, 8'(p + 127 - FB), q[22:0]};
	endfunction

	// Computes what the unit returns for one command.
	function automatic alu_result_t alu_predict(input logic [3:0] op,
			input logic signed [31:0] a, input logic signed [31:0] b);
		alu_result_t        r;
		logic signed [63:0] wide;
		logic [63:0]        na;
		logic [63:0]        nb;
		logic [63:0]        quo;
		r       = '0;
		r.lt    = a < b;
		r.eq    = a == b;
		r.gt    = a > b;
		case (op)
			q248_pkg::OP_ADD:      r.value = a + b;
			q248_pkg::OP_SUB:      r.value = a - b;
			q248_pkg::OP_MUL: begin
				wide    = 64'(a) * 64'(b);
				r.value = 32'(wide >>> FB);
			end
			q248_pkg::OP_DIV: begin
				if (b == 0) begin
					r.err = q248_pkg::ERR_DIV0;
				end else begin
					wide = 64'(a) <<< FB;
					na   = wide < 0 ? 64'(-wide) : 64'(wide);
					nb   = b < 0 ? 64'(-64'(b)) : 64'(b);
					quo  = na / nb;
					if ((wide < 0) != (b < 0))
						quo = -quo;
					r.value = quo[31:0];
				end
			end
			q248_pkg::OP_MIN:      r.value = (a < b) ? a : b;
			q248_pkg::OP_MAX:      r.value = (a > b) ? a : b;
			q248_pkg::OP_INC:      r.value = a + 1;
			q248_pkg::OP_DEC:      r.value = a - 1;
			q248_pkg::OP_FROM_INT: r.value = a << FB;
			q248_pkg::OP_FROM_FLT: r.value = float_to_raw(a, r.err);
			q248_pkg::OP_TO_INT:   r.value = a >>> FB;
			q248_pkg::OP_TO_FLT:   r.value = raw_to_float(a);
			default:               r.value = 32'd0;
		endcase
		return r;
	endfunction

	// Result checker: every done beat is matched to the oldest expectation.
	always @(posedge clk) begin
		alu_result_t exp_r;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result beat: value %h", result_value);
				error_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (result_value !== exp_r.value) begin
					$error("result_value: expected %h, got %h", exp_r.value, result_value);
					error_count++;
				end
				if (a_less !== exp_r.lt) begin
					$error("a_less: expected %b, got %b", exp_r.lt, a_less);
					error_count++;
				end
				if (a_equal !== exp_r.eq) begin
					$error("a_equal: expected %b, got %b", exp_r.eq, a_equal);
					error_count++;
				end
				if (a_greater !== exp_r.gt) begin
					$error("a_greater: expected %b, got %b", exp_r.gt, a_greater);
					error_count++;
				end
				if (error_code !== exp_r.err) begin
					$error("error_code: expected %0d, got %0d", exp_r.err, error_code);
					error_count++;
				end
			end
		end
	end

	// Watchdog: counts cycles where neither a command nor a result beat moves.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Sends one command beat after a random gap, and records its expectation.
	// The typed answer, where given, is cross-checked with the predictor so a
	// slip in the table itself is also caught. Start drops only for a gap, so
	// back-to-back beats keep it high.
	task automatic send_beat(input alu_row_t row);
		int          gap;
		alu_result_t pred;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		opcode    <= row.op;
		operand_a <= row.a;
		operand_b <= row.b;
		pred = row.typed ? row.res : alu_predict(row.op, row.a, row.b);
		if (row.typed && pred !== alu_predict(row.op, row.a, row.b)) begin
			$error("table row op %0d: expected %h, predictor gives %h", row.op, pred,
				alu_predict(row.op, row.a, row.b));
			error_count++;
		end
		do @(posedge clk); while (busy);
		pending_results.push_back(pred);
	endtask

	// Random operand shaped toward interesting values: extremes, small values,
	// well-formed floats (mid-range words for other ops) and fully random words.
	function automatic logic [31:0] pick_operand(input logic [3:0] op);
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 :
				($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'(int'($urandom_range(0, 4)) - 2));
			1: return 32'(int'($urandom_range(0, 4096)) - 2048);
			2: if (op == q248_pkg::OP_FROM_FLT)
				return {1'($urandom), 8'($urandom_range(100, 170)), 23'($urandom)};
			   else
				return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: return $urandom;
		endcase
	endfunction

	alu_row_t directed[$];

	function automatic alu_row_t mk(input logic [3:0] op, input logic [31:0] a,
			input logic [31:0] b, input bit typed = 0, input logic [31:0] v = 0,
			input logic [1:0] e = q248_pkg::ERR_NONE);
		alu_row_t row;
		row.op      = op;
		row.a       = a;
		row.b       = b;
		row.typed   = typed;
		row.res.value = v;
		row.res.lt  = $signed(a) < $signed(b);
		row.res.eq  = a == b;
		row.res.gt  = $signed(a) > $signed(b);
		row.res.err = e;
		return row;
	endfunction

	initial begin
		alu_row_t row;
		logic [3:0] op;
		int wait_cnt;
		error_count = 0;
		start       = 1'b0;
		opcode      = q248_pkg::OP_ADD;
		operand_a   = '0;
		operand_b   = '0;
		arst_n      = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: extremes, every operation and every special case.
		directed.push_back(mk(q248_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1, 1, 32'h8000_0000));
		directed.push_back(mk(q248_pkg::OP_SUB, 32'h8000_0000, 32'd1, 1, 32'h7FFF_FFFF));
		directed.push_back(mk(q248_pkg::OP_MUL, 32'h0000_0180, 32'hFFFF_FE00, 1,
			32'hFFFF_FD00));
		directed.push_back(mk(q248_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000));
		directed.push_back(mk(q248_pkg::OP_DIV, 32'h0000_0100, 32'd0, 1, 32'd0,
			q248_pkg::ERR_DIV0));
		directed.push_back(mk(q248_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF));
		directed.push_back(mk(q248_pkg::OP_DIV, 32'hFFFF_FD00, 32'h0000_0200));
		directed.push_back(mk(q248_pkg::OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1,
			32'h8000_0000));
		directed.push_back(mk(q248_pkg::OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1,
			32'h7FFF_FFFF));
		directed.push_back(mk(q248_pkg::OP_INC, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1,
			32'h8000_0000));
		directed.push_back(mk(q248_pkg::OP_DEC, 32'h8000_0000, 32'h8000_0000, 1,
			32'h7FFF_FFFF));
		directed.push_back(mk(q248_pkg::OP_FROM_INT, 32'd5, 32'd0, 1, 32'h0000_0500));
		directed.push_back(mk(q248_pkg::OP_TO_INT, 32'hFFFF_FF80, 32'd0, 1, 32'hFFFF_FFFF));
		// Float NaN, both infinities, negative zero, a denormal, one, a half-LSB value, out-of-range values.
		directed.push_back(mk(q248_pkg::OP_FROM_FLT, 32'h7FC0_0000, 32'd0, 1, 32'd0,
			q248_pkg::ERR_FLOAT));
		directed.push_back(mk(q248_pkg::OP_FROM_FLT, 32'h7F80_0000, 32'd0, 1, 32'h7FFF_FFFF,
			q248_pkg::ERR_FLOAT));
		directed.push_back(mk(q248_pkg::OP_FROM_FLT, 32'hFF80_0000, 32'd0, 1, 32'h8000_0000,
			q248_pkg::ERR_FLOAT));
		directed.push_back(mk(q248_pkg::OP_FROM_FLT, 32'h8000_0000, 32'd0, 1, 32'd0));
		directed.push_back(mk(q248_pkg::OP_FROM_FLT, 32'h0000_0001, 32'd0, 1, 32'd0));
		directed.push_back(mk(q248_pkg::OP_FROM_FLT, 32'h3F80_0000, 32'd0, 1, 32'h0000_0100));
		directed.push_back(mk(q248_pkg::OP_FROM_FLT, 32'hBB00_0000, 32'd0));
		directed.push_back(mk(q248_pkg::OP_FROM_FLT, 32'hCF00_0000, 32'd0, 1, 32'h8000_0000,
			q248_pkg::ERR_FLOAT));
		directed.push_back(mk(q248_pkg::OP_FROM_FLT, 32'h4B00_0000, 32'd0, 1, 32'h7FFF_FFFF,
			q248_pkg::ERR_FLOAT));
		directed.push_back(mk(q248_pkg::OP_TO_FLT, 32'h0000_0100, 32'd0, 1, 32'h3F80_0000));
		directed.push_back(mk(q248_pkg::OP_TO_FLT, 32'h8000_0000, 32'd0, 1, 32'hCB00_0000));
		directed.push_back(mk(q248_pkg::OP_TO_FLT, 32'h7FFF_FFFF, 32'd0));
		directed.push_back(mk(4'd12, 32'd3, 32'd3, 1, 32'd0));
		directed.push_back(mk(4'd15, 32'hFFFF_FFFF, 32'd1, 1, 32'd0));

		foreach (directed[i])
			send_beat(directed[i]);

		// Random part: mostly defined opcodes, a few of the unused ones.
		for (int n = 0; n < N_RANDOM; n++) begin
			op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15)) :
				4'($urandom_range(q248_pkg::OP_ADD, q248_pkg::OP_TO_FLT));
			row = mk(op, pick_operand(op), pick_operand(op));
			if ($urandom_range(0, 7) == 0)
				row.b = row.a;
			send_beat(row);
		end
		start <= 1'b0;

		// Drain: wait for every expected beat, then let the pipeline run empty.
		wait_cnt = 0;
		while (pending_results.size() != 0 && wait_cnt < 4 * LATENCY + 100) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (LATENCY + 4) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			if (pending_results.size() != 0)
				$error("%0d result beats never arrived", pending_results.size());
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

// File: files.f
rtl/core/q248_pkg.sv
rtl/core/q248_div_cell.sv
rtl/core/fixed_point_q24_8_alu.sv
dv/fixed_point_q24_8_alu_tb.sv
